[src/ray_box_slab_test_unit_defines.svh]
// Assertion macros shared by the ray-box slab test checker.
// Every macro expects clk and arst_n to be visible where it is used.
`ifndef RAY_BOX_SLAB_TEST_UNIT_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RBST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define RBST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/rbst_pkg.sv]
// Shared constants of the ray-box slab test pipeline.
// No dependencies; imported by rbst_prep, rbst_div, rbst_merge and the top level.
`timescale 1ns / 1ps

package rbst_pkg;
	// Three axes; each axis feeds two divider lanes (min and max slab plane).
	localparam int NUM_AXES = 3;
	localparam int NUM_LANES = 2 * NUM_AXES;
	// Sideband bits per word: lane signs, parallel flags, outside flags.
	localparam int SIDE_WIDTH = NUM_LANES + 2 * NUM_AXES;
	// Parallel threshold register.
	localparam int THR_WIDTH = 17;
	localparam logic [THR_WIDTH-1:0] THR_RESET = 17'd1;
	// Register stages after the divider.
	localparam int MERGE_STAGES = 3;
endpackage

[src/rbst_prep.sv]
// Input stage: slab differences, magnitudes, signs and parallel tests.
// Depends on rbst_pkg.
`timescale 1ns / 1ps

module rbst_prep #(
	parameter int CW = 32
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [CW-1:0]             origin [rbst_pkg::NUM_AXES],
	input  logic signed [CW-1:0]             dir    [rbst_pkg::NUM_AXES],
	input  logic signed [CW-1:0]             bmin   [rbst_pkg::NUM_AXES],
	input  logic signed [CW-1:0]             bmax   [rbst_pkg::NUM_AXES],
	input  logic [rbst_pkg::THR_WIDTH-1:0]   thr,
	output logic [CW-1:0]                    num_s1 [rbst_pkg::NUM_LANES],
	output logic [CW-1:0]                    den_s1 [rbst_pkg::NUM_LANES],
	output logic [rbst_pkg::SIDE_WIDTH-1:0]  side_s1
);
	import rbst_pkg::*;

	localparam int CMPW = (CW > THR_WIDTH) ? CW : THR_WIDTH;

	logic [CW-1:0]        num_c [NUM_LANES];
	logic [CW-1:0]        den_c [NUM_LANES];
	logic [NUM_LANES-1:0] neg_c;
	logic [NUM_AXES-1:0]  par_c;
	logic [NUM_AXES-1:0]  out_c;

	// Differences to both slab planes and their magnitudes, per axis.
	always_comb begin
		logic [CW:0]   dlo, dhi, alo, ahi;
		logic [CW-1:0] dmag;
		for (int a = 0; a < NUM_AXES; a++) begin
			dlo = {bmin[a][CW-1], bmin[a]} - {origin[a][CW-1], origin[a]};
			dhi = {bmax[a][CW-1], bmax[a]} - {origin[a][CW-1], origin[a]};
			alo = dlo[CW] ? (~dlo + 1'b1) : dlo;
			ahi = dhi[CW] ? (~dhi + 1'b1) : dhi;
			dmag = dir[a][CW-1] ? (~dir[a] + 1'b1) : dir[a];
			num_c[a] = alo[CW-1:0];
			num_c[NUM_AXES+a] = ahi[CW-1:0];
			den_c[a] = dmag;
			den_c[NUM_AXES+a] = dmag;
			neg_c[a] = (dlo[CW] ^ dir[a][CW-1]) && (dlo != '0);
			neg_c[NUM_AXES+a] = (dhi[CW] ^ dir[a][CW-1]) && (dhi != '0);
			par_c[a] = (dir[a] == '0) || (CMPW'(dmag) < CMPW'(thr));
			out_c[a] = (origin[a] < bmin[a]) || (origin[a] > bmax[a]);
		end
	end

	// First pipeline register.
	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= num_c;
			den_s1 <= den_c;
			side_s1 <= {neg_c, par_c, out_c};
		end
	end
endmodule

[src/rbst_div.sv]
// Pipelined restoring divider, one quotient bit per stage, six lanes.
// Depends on rbst_pkg; yields CW-1 quotient bits and an overflow flag per lane.
`timescale 1ns / 1ps

module rbst_div #(
	parameter int CW = 32,
	parameter int FB = 16
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [CW-1:0]                    num [rbst_pkg::NUM_LANES],
	input  logic [CW-1:0]                    den [rbst_pkg::NUM_LANES],
	input  logic [rbst_pkg::SIDE_WIDTH-1:0]  side,
	output logic [CW-2:0]                    quo [rbst_pkg::NUM_LANES],
	output logic [rbst_pkg::NUM_LANES-1:0]   ovf,
	output logic [rbst_pkg::SIDE_WIDTH-1:0]  side_out
);
	import rbst_pkg::*;

	// Dividend is num shifted up by the fraction bits.
	localparam int NW = CW + FB;

	logic [NW-1:0]         nsh_sk  [NW+1][NUM_LANES];
	logic [CW-1:0]         rem_sk  [NW+1][NUM_LANES];
	logic [CW-1:0]         den_sk  [NW+1][NUM_LANES];
	logic [CW-2:0]         quo_sk  [NW+1][NUM_LANES];
	logic [NUM_LANES-1:0]  ovf_sk  [NW+1];
	logic [SIDE_WIDTH-1:0] side_sk [NW+1];

	// Entry point of the divider chain.
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			nsh_sk[0][l] = {num[l], {FB{1'b0}}};
			rem_sk[0][l] = '0;
			den_sk[0][l] = den[l];
			quo_sk[0][l] = '0;
		end
		ovf_sk[0] = '0;
		side_sk[0] = side;
	end

	for (genvar k = 0; k < NW; k++) begin : g_stage
		// Quotient bits of weight 2^(CW-1) and above mean saturation.
		localparam bit HIGH_BIT = (k <= FB);

		logic [CW-1:0]        rem_n [NUM_LANES];
		logic [CW-2:0]        quo_n [NUM_LANES];
		logic [NUM_LANES-1:0] ge_n;

		// One trial subtraction per lane.
		always_comb begin
			logic [CW:0] r2;
			for (int l = 0; l < NUM_LANES; l++) begin
				r2 = {rem_sk[k][l], nsh_sk[k][l][NW-1]};
				ge_n[l] = (r2 >= {1'b0, den_sk[k][l]});
				r2 = ge_n[l] ? (r2 - {1'b0, den_sk[k][l]}) : r2;
				rem_n[l] = r2[CW-1:0];
				quo_n[l] = {quo_sk[k][l][CW-3:0], ge_n[l]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < NUM_LANES; l++) begin
					nsh_sk[k+1][l] <= {nsh_sk[k][l][NW-2:0], 1'b0};
					rem_sk[k+1][l] <= rem_n[l];
					den_sk[k+1][l] <= den_sk[k][l];
					quo_sk[k+1][l] <= quo_n[l];
				end
				ovf_sk[k+1] <= ovf_sk[k] | (HIGH_BIT ? ge_n : '0);
				side_sk[k+1] <= side_sk[k];
			end
		end
	end

	assign quo = quo_sk[NW];
	assign ovf = ovf_sk[NW];
	assign side_out = side_sk[NW];
endmodule

[src/rbst_merge.sv]
// Back end: signed saturated distances, slab ordering, interval and hit flag.
// Depends on rbst_pkg; the last stage is the output register.
`timescale 1ns / 1ps

module rbst_merge #(
	parameter int CW = 32
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [CW-2:0]                    quo [rbst_pkg::NUM_LANES],
	input  logic [rbst_pkg::NUM_LANES-1:0]   ovf,
	input  logic [rbst_pkg::SIDE_WIDTH-1:0]  side,
	output logic                             hit_s3,
	output logic signed [CW-1:0]             tn_s3,
	output logic signed [CW-1:0]             tf_s3
);
	import rbst_pkg::*;

	localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};

	logic [NUM_LANES-1:0] neg;
	logic [NUM_AXES-1:0]  par, outside;
	assign {neg, par, outside} = side;

	logic signed [CW-1:0] lo_c [NUM_AXES];
	logic signed [CW-1:0] hi_c [NUM_AXES];
	logic signed [CW-1:0] lo_s1 [NUM_AXES];
	logic signed [CW-1:0] hi_s1 [NUM_AXES];
	logic [NUM_AXES-1:0]  par_s1, out_s1;
	logic signed [CW-1:0] tn_c, tf_c, tn_s2, tf_s2;
	logic                 pmiss_s2;

	// Apply sign and saturation, then order the two slab distances.
	always_comb begin
		logic signed [CW-1:0] t [NUM_LANES];
		logic signed [CW-1:0] mag;
		for (int l = 0; l < NUM_LANES; l++) begin
			mag = {1'b0, quo[l]};
			if (ovf[l])
				t[l] = neg[l] ? T_MIN : T_MAX;
			else
				t[l] = neg[l] ? -mag : mag;
		end
		for (int a = 0; a < NUM_AXES; a++) begin
			lo_c[a] = (t[a] > t[NUM_AXES+a]) ? t[NUM_AXES+a] : t[a];
			hi_c[a] = (t[a] > t[NUM_AXES+a]) ? t[a] : t[NUM_AXES+a];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1 <= lo_c;
			hi_s1 <= hi_c;
			par_s1 <= par;
			out_s1 <= outside;
		end
	end

	// Narrow the interval over the non-parallel axes.
	always_comb begin
		tn_c = T_MIN;
		tf_c = T_MAX;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (!par_s1[a]) begin
				if (lo_s1[a] > tn_c)
					tn_c = lo_s1[a];
				if (hi_s1[a] < tf_c)
					tf_c = hi_s1[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tn_s2 <= tn_c;
			tf_s2 <= tf_c;
			pmiss_s2 <= |(par_s1 & out_s1);
		end
	end

	// Final verdict; distances read zero on a miss.
	always_ff @(posedge clk) begin
		logic h;
		if (en) begin
			h = !pmiss_s2 && !(tn_s2 > tf_s2) && !tf_s2[CW-1];
			hit_s3 <= h;
			tn_s3 <= h ? tn_s2 : '0;
			tf_s3 <= h ? tf_s2 : '0;
		end
	end
endmodule

[src/ray_box_slab_test_unit.sv]
// Top level of the ray versus axis-aligned box slab test.
// Depends on rbst_pkg, rbst_prep, rbst_div and rbst_merge.
//
//  channel | handshake              | word
//  --------+------------------------+---------------------------------------------
//  in      | in_valid / in_ready    | origin_*, dir_*, box_min_*, box_max_*
//  out     | out_valid / out_ready  | hit, t_entry, t_exit
//  cfg     | cfg_wr_en              | cfg_wr_data (parallel threshold)
//
// One word is accepted per cycle unless the output word is held; each word passes
// through the input register, the bit-per-stage divider chain and the merge registers.
// Reset clears the stage valid bits and loads a threshold of 1.
// A stall at the output freezes every stage together; nothing is dropped or repeated.
`timescale 1ns / 1ps

module ray_box_slab_test_unit #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [COORD_WIDTH-1:0]   origin_x,
	input  logic signed [COORD_WIDTH-1:0]   origin_y,
	input  logic signed [COORD_WIDTH-1:0]   origin_z,
	input  logic signed [COORD_WIDTH-1:0]   dir_x,
	input  logic signed [COORD_WIDTH-1:0]   dir_y,
	input  logic signed [COORD_WIDTH-1:0]   dir_z,
	input  logic signed [COORD_WIDTH-1:0]   box_min_x,
	input  logic signed [COORD_WIDTH-1:0]   box_min_y,
	input  logic signed [COORD_WIDTH-1:0]   box_min_z,
	input  logic signed [COORD_WIDTH-1:0]   box_max_x,
	input  logic signed [COORD_WIDTH-1:0]   box_max_y,
	input  logic signed [COORD_WIDTH-1:0]   box_max_z,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic signed [COORD_WIDTH-1:0]   t_entry,
	output logic signed [COORD_WIDTH-1:0]   t_exit,
	input  logic                            cfg_wr_en,
	input  logic [rbst_pkg::THR_WIDTH-1:0]  cfg_wr_data
);
	import rbst_pkg::*;

	localparam int DEPTH = 1 + COORD_WIDTH + FRAC_BITS + MERGE_STAGES;

	logic [THR_WIDTH-1:0]   thr_q;
	logic [DEPTH-1:0]       vld_q;
	logic                   en;

	logic signed [COORD_WIDTH-1:0] origin [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] dir    [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] bmin   [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] bmax   [NUM_AXES];

	logic [COORD_WIDTH-1:0] num_s1 [NUM_LANES];
	logic [COORD_WIDTH-1:0] den_s1 [NUM_LANES];
	logic [SIDE_WIDTH-1:0]  side_s1, side_d;
	logic [COORD_WIDTH-2:0] quo_d [NUM_LANES];
	logic [NUM_LANES-1:0]   ovf_d;

	assign origin = '{origin_x, origin_y, origin_z};
	assign dir    = '{dir_x, dir_y, dir_z};
	assign bmin   = '{box_min_x, box_min_y, box_min_z};
	assign bmax   = '{box_max_x, box_max_y, box_max_z};

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// The whole pipeline moves unless the output word is held.
	assign en = !vld_q[DEPTH-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	rbst_prep #(.CW(COORD_WIDTH)) u_prep (
		.clk     (clk),
		.en      (en),
		.origin  (origin),
		.dir     (dir),
		.bmin    (bmin),
		.bmax    (bmax),
		.thr     (thr_q),
		.num_s1  (num_s1),
		.den_s1  (den_s1),
		.side_s1 (side_s1)
	);

	rbst_div #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_div (
		.clk      (clk),
		.en       (en),
		.num      (num_s1),
		.den      (den_s1),
		.side     (side_s1),
		.quo      (quo_d),
		.ovf      (ovf_d),
		.side_out (side_d)
	);

	rbst_merge #(.CW(COORD_WIDTH)) u_merge (
		.clk    (clk),
		.en     (en),
		.quo    (quo_d),
		.ovf    (ovf_d),
		.side   (side_d),
		.hit_s3 (hit),
		.tn_s3  (t_entry),
		.tf_s3  (t_exit)
	);
endmodule

[src/rbst_checker.sv]
// Port-level checks of the ray-box slab test unit, bound to the top level.
// Depends on ray_box_slab_test_unit_defines.svh.
`timescale 1ns / 1ps
`include "ray_box_slab_test_unit_defines.svh"

module rbst_checker #(
	parameter int CW = 32
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 hit,
	input logic signed [CW-1:0] t_entry,
	input logic signed [CW-1:0] t_exit
);
	logic [2*CW:0] out_word;

	assign out_word = {hit, t_entry, t_exit};

	// A held output word stays valid and unchanged.
	`RBST_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "output word dropped")
	`RBST_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_word), "held word changed")
	// A miss reports zero distances.
	`RBST_ASSERT_IMP(a_miss_zero, out_valid && !hit, (t_entry == 0) && (t_exit == 0), "miss with distance")
	// A hit has a nonnegative exit that does not come before the entry.
	`RBST_ASSERT_IMP(a_hit_exit, out_valid && hit, !t_exit[CW-1], "hit with negative exit")
	`RBST_ASSERT_IMP(a_hit_order, out_valid && hit, t_entry <= t_exit, "hit with entry after exit")
endmodule

bind ray_box_slab_test_unit rbst_checker #(.CW(COORD_WIDTH)) u_rbst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.hit       (hit),
	.t_entry   (t_entry),
	.t_exit    (t_exit)
);

[verif/tb_top.sv]
// Self-checking testbench for the ray versus axis-aligned box slab test unit.
// Depends on rbst_pkg and ray_box_slab_test_unit; predicts each result in SystemVerilog.
`timescale 1ns / 1ps

module tb_top;
	import rbst_pkg::*;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int LATENCY = CW + FB + 4;

	typedef struct {
		logic signed [CW-1:0] org [3];
		logic signed [CW-1:0] dir [3];
		logic signed [CW-1:0] bmin [3];
		logic signed [CW-1:0] bmax [3];
	} ray_box_t;

	typedef struct {
		logic hit;
		logic signed [CW-1:0] t_entry;
		logic signed [CW-1:0] t_exit;
	} slab_hit_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [CW-1:0] origin_x, origin_y, origin_z;
	logic signed [CW-1:0] dir_x, dir_y, dir_z;
	logic signed [CW-1:0] box_min_x, box_min_y, box_min_z;
	logic signed [CW-1:0] box_max_x, box_max_y, box_max_z;
	logic out_valid;
	logic out_ready;
	logic hit;
	logic signed [CW-1:0] t_entry, t_exit;
	logic cfg_wr_en;
	logic [THR_WIDTH-1:0] cfg_wr_data;

	// Threshold as the predictor sees it.
	logic [THR_WIDTH-1:0] model_threshold;
	slab_hit_t pending_hits [$];
	int error_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_cycles;

	ray_box_slab_test_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
		.box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .t_entry(t_entry), .t_exit(t_exit),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#60ms;
		$display("** ray_box_slab_test_unit: FAILED **");
		$finish;
	end

	// Scaled division truncated toward zero, saturated to the coordinate range.
	function automatic logic signed [63:0] slab_distance(logic signed [63:0] num,
			logic signed [63:0] den);
		logic [63:0] n;
		logic [63:0] d;
		logic [63:0] q;
		logic neg;
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		neg = ((num < 0) != (den < 0)) && n != 0;
		if (n / d >= (64'd1 << (CW - 1 - FB)))
			return neg ? -(64'sd1 <<< (CW - 1)) : (64'sd1 <<< (CW - 1)) - 1;
		q = (n << FB) / d;
		return neg ? -$signed(q) : $signed(q);
	endfunction

	// Runs the three slab tests in order, stopping at the first miss.
	function automatic slab_hit_t predict_slab_hit(ray_box_t rb);
		slab_hit_t r;
		logic signed [63:0] near_t;
		logic signed [63:0] far_t;
		logic signed [63:0] t1, t2, tmp, o, d, lo, hi;
		logic [63:0] dmag;
		logic ok;
		near_t = -(64'sd1 <<< (CW - 1));
		far_t = (64'sd1 <<< (CW - 1)) - 1;
		ok = 1'b1;
		for (int a = 0; a < 3 && ok; a++) begin
			o = rb.org[a];
			d = rb.dir[a];
			lo = rb.bmin[a];
			hi = rb.bmax[a];
			dmag = d < 0 ? -d : d;
			if (d == 0 || dmag < model_threshold) begin
				if (o < lo || o > hi)
					ok = 1'b0;
			end else begin
				t1 = slab_distance(lo - o, d);
				t2 = slab_distance(hi - o, d);
				if (t1 > t2) begin
					tmp = t1;
					t1 = t2;
					t2 = tmp;
				end
				if (t1 > near_t)
					near_t = t1;
				if (t2 < far_t)
					far_t = t2;
				if (near_t > far_t)
					ok = 1'b0;
			end
		end
		if (ok && far_t < 0)
			ok = 1'b0;
		r.hit = ok;
		r.t_entry = ok ? near_t[CW-1:0] : '0;
		r.t_exit = ok ? far_t[CW-1:0] : '0;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic signed [CW-1:0] got,
			logic signed [CW-1:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	// Drives one word and waits for its acceptance; the expectation is queued at that edge.
	// Valid stays up afterwards so the next word can follow at once; drain drops it.
	task automatic send_ray_box(ray_box_t rb);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		origin_x <= rb.org[0]; origin_y <= rb.org[1]; origin_z <= rb.org[2];
		dir_x <= rb.dir[0]; dir_y <= rb.dir[1]; dir_z <= rb.dir[2];
		box_min_x <= rb.bmin[0]; box_min_y <= rb.bmin[1]; box_min_z <= rb.bmin[2];
		box_max_x <= rb.bmax[0]; box_max_y <= rb.bmax[1]; box_max_z <= rb.bmax[2];
		do
			@(posedge clk);
		while (!in_ready);
		pending_hits.insert(pending_hits.size(), predict_slab_hit(rb));
	endtask

	// Stops offering words, then waits until every expected word has arrived.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_threshold(logic [THR_WIDTH-1:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_threshold = value;
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
			2: return ($urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000) - $urandom_range(3);
			default: return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
		endcase
	endfunction

	function automatic logic signed [CW-1:0] rand_dir();
		case ($urandom_range(5))
			0: return 0;
			1: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
			2: return $urandom;
			default: return $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000;
		endcase
	endfunction

	// Mostly boxes placed around the ray so the later axes are reached.
	function automatic ray_box_t rand_ray_box();
		ray_box_t rb;
		logic signed [CW-1:0] span;
		for (int a = 0; a < 3; a++) begin
			rb.org[a] = rand_coord();
			rb.dir[a] = rand_dir();
			if ($urandom_range(9) < 7) begin
				span = $urandom_range(1, 32'h00FFFFFF);
				rb.bmin[a] = rb.org[a] + $signed(32'($urandom_range(0, 32'h01FFFFFF)))
					- 32'sh01000000;
				rb.bmax[a] = rb.bmin[a] + ($urandom_range(9) == 0 ? -span : span);
			end else begin
				rb.bmin[a] = rand_coord();
				rb.bmax[a] = rand_coord();
			end
		end
		return rb;
	endfunction

	function automatic ray_box_t make_ray_box(logic signed [CW-1:0] o,
			logic signed [CW-1:0] d, logic signed [CW-1:0] lo, logic signed [CW-1:0] hi);
		ray_box_t rb;
		for (int a = 0; a < 3; a++) begin
			rb.org[a] = o; rb.dir[a] = d; rb.bmin[a] = lo; rb.bmax[a] = hi;
		end
		return rb;
	endfunction

	task automatic run_random(int count);
		repeat (count) send_ray_box(rand_ray_box());
	endtask

	// Extremes, zero and near-threshold directions, inverted boxes, saturation.
	task automatic test_directed;
		ray_box_t rb;
		send_ray_box(make_ray_box(0, 32'sh10000, -32'sh10000, 32'sh10000));
		send_ray_box(make_ray_box(0, 0, -32'sh10000, 32'sh10000));
		send_ray_box(make_ray_box(32'sh20000, 0, -32'sh10000, 32'sh10000));
		send_ray_box(make_ray_box(0, 1, 32'sh7FFFFFFF, 32'sh80000000));
		send_ray_box(make_ray_box(32'sh80000000, 1, 32'sh80000000, 32'sh7FFFFFFF));
		send_ray_box(make_ray_box(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF));
		send_ray_box(make_ray_box(0, -1, -32'sh10000, 32'sh10000));
		send_ray_box(make_ray_box(0, 32'sh7FFFFFFF, -1, 1));
		send_ray_box(make_ray_box(0, 32'sh10000, 32'sh10000, -32'sh10000));
		send_ray_box(make_ray_box(0, 0, 32'sh10000, -32'sh10000));
		send_ray_box(make_ray_box(32'sh50000, 32'sh10000, -32'sh10000, 32'sh10000));
		send_ray_box(make_ray_box(32'shFFFFFFFF, 32'shFFFFFFFF, 32'sh7FFFFFFF, 32'sh80000000));
		rb = make_ray_box(0, 32'sh10000, -32'sh10000, 32'sh10000);
		rb.bmin[1] = 32'sh50000; rb.bmax[1] = 32'sh60000; rb.dir[1] = 0;
		send_ray_box(rb);
		rb.dir[1] = 32'shFFFF0000;
		send_ray_box(rb);
	endtask

	// Threshold sweep, extremes included, with a near-threshold direction.
	task automatic test_threshold;
		logic [THR_WIDTH-1:0] thr [5] = '{17'd0, 17'd65536, 17'd1, 17'd300, 17'h1FFFF};
		foreach (thr[i]) begin
			write_threshold(thr[i]);
			send_ray_box(make_ray_box(0, CW'(thr[i]), -32'sh10000, 32'sh10000));
			send_ray_box(make_ray_box(0, 32'sd1 - $signed(CW'(thr[i])), 32'sh10000,
				32'sh20000));
			run_random(100);
		end
		write_threshold(17'd1);
	endtask

	// Output held off for a long stretch while the input keeps offering.
	task automatic test_backpressure;
		hold_off_cycles = 300;
		run_random(120);
		drain();
		run_random(30);
	endtask

	task automatic test_idling;
		int pct [4][2] = '{'{0, 0}, '{79, 0}, '{0, 79}, '{10, 10}};
		foreach (pct[i]) begin
			send_idle_pct = pct[i][0];
			recv_stall_pct = pct[i][1];
			run_random(300);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// Receiver side: random stalls plus the long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// Checks every accepted result against the oldest expectation.
	always @(posedge clk) begin
		slab_hit_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_hits.size() == 0) begin
				$display("unexpected result word at %0t", $realtime);
				error_count++;
			end else begin
				want = pending_hits.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", CW'(hit), CW'(want.hit));
				if (t_entry !== want.t_entry)
					report_mismatch("t_entry", t_entry, want.t_entry);
				if (t_exit !== want.t_exit)
					report_mismatch("t_exit", t_exit, want.t_exit);
			end
		end
	end

	initial begin
		error_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		model_threshold = THR_RESET;
		arst_n = 1'b0;
		in_valid = 1'b0;
		{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} = '0;
		{box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z} = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_threshold();
		test_backpressure();
		test_idling();
		drain();
		if (error_count == 0)
			$display("** ray_box_slab_test_unit: PASSED **");
		else
			$display("** ray_box_slab_test_unit: FAILED **");
		$finish;
	end
endmodule
